// File: hw/rtl/ftt_pkg.sv
// shared constants, types and state codes of the frame time to texture lookup
package ftt_pkg;

    localparam int MAX_FRAMES   = 32;
    localparam int TEXTURE_BITS = 16;
    localparam int DELAY_BITS   = 32;

    localparam int TEX_PORT_BITS   = 16;
    localparam int DELAY_PORT_BITS = 32;
    localparam int ELAPSED_BITS    = 64;

    localparam int IDX_BITS   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int COUNT_BITS = $clog2(MAX_FRAMES + 1);
    localparam int TOTAL_BITS = DELAY_BITS + $clog2(MAX_FRAMES);
    localparam int STEP_BITS  = $clog2(ELAPSED_BITS + 1);

    localparam logic KIND_APPEND = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    typedef struct packed {
        logic                       kind;
        logic [TEX_PORT_BITS-1:0]   texture_in;
        logic [DELAY_PORT_BITS-1:0] frame_delay;
        logic [ELAPSED_BITS-1:0]    elapsed_time;
    } item_beat_t;

    typedef struct packed {
        logic [TEX_PORT_BITS-1:0] texture_out;
        logic                     texture_valid;
        logic                     table_full;
    } result_beat_t;

    typedef struct packed {
        logic [TEXTURE_BITS-1:0] texture;
        logic [DELAY_BITS-1:0]   delay;
    } frame_entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_WALK,
        ST_DONE
    } ftt_state_t;

endpackage

// File: hw/rtl/ftt_item_if.sv
// input channel carrying append and query beats
interface ftt_item_if;
    import ftt_pkg::*;

    logic       valid;
    logic       ready;
    item_beat_t beat;

    modport source (output valid, output beat, input ready);
    modport sink   (input valid, input beat, output ready);
endinterface

// File: hw/rtl/ftt_result_if.sv
// output channel carrying result beats
interface ftt_result_if;
    import ftt_pkg::*;

    logic         valid;
    logic         ready;
    result_beat_t beat;

    modport source (output valid, output beat, input ready);
    modport sink   (input valid, input beat, output ready);
endinterface

// File: hw/rtl/ftt_frame_ram.sv
// frame table memory: one write port, one registered read port
module ftt_frame_ram (
    input  logic                           clk,
    input  logic                           we,
    input  logic [ftt_pkg::IDX_BITS-1:0]   waddr,
    input  ftt_pkg::frame_entry_t          wdata,
    input  logic                           re,
    input  logic [ftt_pkg::IDX_BITS-1:0]   raddr,
    output ftt_pkg::frame_entry_t          rdata
);
    import ftt_pkg::*;

    frame_entry_t mem [MAX_FRAMES];
    frame_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// File: hw/rtl/ftt_modulo.sv
// bit-serial restoring remainder of the elapsed time by the total duration
module ftt_modulo (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [ftt_pkg::ELAPSED_BITS-1:0]  dividend,
    input  logic [ftt_pkg::TOTAL_BITS-1:0]    divisor,
    output logic                              done,
    output logic [ftt_pkg::TOTAL_BITS-1:0]    remainder
);
    import ftt_pkg::*;

    logic [ELAPSED_BITS-1:0] dvd_reg, dvd_next;
    logic [TOTAL_BITS-1:0]   div_reg, div_next;
    logic [TOTAL_BITS-1:0]   rem_reg, rem_next;
    logic [STEP_BITS-1:0]    cnt_reg, cnt_next;
    logic                    done_reg, done_next;
    logic [TOTAL_BITS:0]     shifted;
    logic [TOTAL_BITS:0]     diff;

    always_comb
    begin
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, dvd_reg[ELAPSED_BITS-1]};
        diff      = shifted - {1'b0, div_reg};
        if (start)
        begin
            dvd_next = dividend;
            div_next = divisor;
            rem_next = '0;
            cnt_next = STEP_BITS'(ELAPSED_BITS);
        end
        else if (cnt_reg != '0)
        begin
            dvd_next = {dvd_reg[ELAPSED_BITS-2:0], 1'b0};
            if (shifted >= {1'b0, div_reg})
            begin
                rem_next = diff[TOTAL_BITS-1:0];
            end
            else
            begin
                rem_next = shifted[TOTAL_BITS-1:0];
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == STEP_BITS'(1))
            begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;
endmodule

// File: hw/rtl/frame_time_to_texture_lookup.sv
// top level of the frame time to texture lookup
// An append beat writes its frame into the table in the cycle it is taken and
// its registered result appears in the cycle after; a full table drops it and flags
// table_full. A query beat takes the elapsed time modulo the running total
// duration in a bit-serial unit (one dividend bit a cycle), then walks the
// frame memory entry by entry behind its registered read port until a hit
// or the last frame; an empty table or a zero total answers from idle with
// an empty result. One beat is worked on at a time; a finished result waits
// in an output register, and the next beat is taken only once that register
// is free or being read.
module frame_time_to_texture_lookup (
    input  logic         clk,
    input  logic         rst_n,
    ftt_item_if.sink     item,
    ftt_result_if.source result
);
    import ftt_pkg::*;

    ftt_state_t            state_reg, state_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [TOTAL_BITS-1:0] total_reg, total_next;
    logic                  out_vld_reg, out_vld_next;
    result_beat_t          out_beat_reg, out_beat_next;
    result_beat_t          res_reg, res_next;
    logic [COUNT_BITS-1:0] rd_idx_reg, rd_idx_next;
    logic [IDX_BITS-1:0]   chk_idx_reg, chk_idx_next;
    logic                  chk_vld_reg, chk_vld_next;
    logic [TOTAL_BITS-1:0] start_reg, start_next;

    logic                  slot_free;
    logic                  accept;
    logic                  ram_we;
    logic                  ram_re;
    frame_entry_t          ram_wdata;
    frame_entry_t          ram_rdata;
    logic                  mod_start;
    logic                  mod_done;
    logic [TOTAL_BITS-1:0] mod_rem;
    logic [TOTAL_BITS:0]   sum;
    logic [TOTAL_BITS-1:0] frame_end;

    ftt_frame_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[IDX_BITS-1:0]),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_idx_reg[IDX_BITS-1:0]),
        .rdata (ram_rdata)
    );

    ftt_modulo u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (item.beat.elapsed_time),
        .divisor   (total_reg),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    assign slot_free   = !out_vld_reg || result.ready;
    assign item.ready  = (state_reg == ST_IDLE) && slot_free;
    assign accept      = item.valid && item.ready;
    assign ram_wdata.texture = TEXTURE_BITS'(item.beat.texture_in);
    assign ram_wdata.delay   = DELAY_BITS'(item.beat.frame_delay);
    assign sum         = {1'b0, total_reg} + (TOTAL_BITS + 1)'(ram_wdata.delay);
    assign frame_end   = start_reg + TOTAL_BITS'(ram_rdata.delay);

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        total_next    = total_reg;
        out_vld_next  = out_vld_reg && !result.ready;
        out_beat_next = out_beat_reg;
        res_next      = res_reg;
        rd_idx_next   = rd_idx_reg;
        chk_idx_next  = chk_idx_reg;
        chk_vld_next  = chk_vld_reg;
        start_next    = start_reg;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        mod_start     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    out_beat_next = '0;
                    if (item.beat.kind == KIND_APPEND)
                    begin
                        out_vld_next = 1'b1;
                        if (count_reg >= COUNT_BITS'(MAX_FRAMES))
                        begin
                            out_beat_next.table_full = 1'b1;
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            count_next = count_reg + 1'b1;
                            total_next = sum[TOTAL_BITS] ? '1 : sum[TOTAL_BITS-1:0];
                        end
                    end
                    else if (count_reg == '0 || total_reg == '0)
                    begin
                        out_vld_next = 1'b1;
                    end
                    else
                    begin
                        mod_start  = 1'b1;
                        state_next = ST_MOD;
                    end
                end
            end
            ST_MOD:
            begin
                if (mod_done)
                begin
                    rd_idx_next = '0;
                    chk_vld_next = 1'b0;
                    start_next  = '0;
                    state_next  = ST_WALK;
                end
            end
            ST_WALK:
            begin
                ram_re       = 1'b1;
                rd_idx_next  = rd_idx_reg + 1'b1;
                chk_idx_next = rd_idx_reg[IDX_BITS-1:0];
                chk_vld_next = rd_idx_reg < count_reg;
                if (chk_vld_reg)
                begin
                    if (mod_rem < frame_end)
                    begin
                        res_next.texture_out   = TEX_PORT_BITS'(ram_rdata.texture);
                        res_next.texture_valid = 1'b1;
                        res_next.table_full    = 1'b0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        start_next = frame_end;
                        if (chk_idx_reg == IDX_BITS'(count_reg - 1'b1))
                        begin
                            res_next   = '0;
                            state_next = ST_DONE;
                        end
                    end
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    out_vld_next  = 1'b1;
                    out_beat_next = res_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            total_reg   <= '0;
            out_vld_reg <= 1'b0;
            chk_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            total_reg   <= total_next;
            out_vld_reg <= out_vld_next;
            chk_vld_reg <= chk_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_beat_reg <= out_beat_next;
        res_reg      <= res_next;
        rd_idx_reg   <= rd_idx_next;
        chk_idx_reg  <= chk_idx_next;
        start_reg    <= start_next;
    end

    assign result.valid = out_vld_reg;
    assign result.beat  = out_beat_reg;
endmodule
